[design/mre_pkg.sv]
// ----------------------------------------------------------------------------
// mre_pkg: shared definitions for the R-type execute block
// Function codes, sequencer states and the request bundle that the execute
// control hands to the iterative multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mre_pkg;

    // Instruction field widths and fixed values.
    localparam int unsigned XLEN = 32;
    localparam int unsigned REG_CNT = 32;
    localparam int unsigned RIDX_W = $clog2(REG_CNT);

    localparam logic [5:0]        OPC_SPECIAL = 6'h00;
    localparam logic [RIDX_W-1:0] LINK_REG    = 5'd31;
    localparam logic [XLEN-1:0]   PC_STEP     = 32'd4;

    // Last iteration index of the multiply/divide unit (one bit per step).
    localparam logic [4:0] MD_LAST = 5'd31;

    // Function codes of the SPECIAL opcode.
    localparam logic [5:0] F_SLL  = 6'h00;
    localparam logic [5:0] F_SRL  = 6'h02;
    localparam logic [5:0] F_SRA  = 6'h03;
    localparam logic [5:0] F_SLLV = 6'h04;
    localparam logic [5:0] F_SRLV = 6'h06;
    localparam logic [5:0] F_SRAV = 6'h07;
    localparam logic [5:0] F_JR   = 6'h08;
    localparam logic [5:0] F_JALR = 6'h09;
    localparam logic [5:0] F_MFHI = 6'h10;
    localparam logic [5:0] F_MFLO = 6'h12;
    localparam logic [5:0] F_MULT = 6'h18;
    localparam logic [5:0] F_MULTU = 6'h19;
    localparam logic [5:0] F_DIV  = 6'h1A;
    localparam logic [5:0] F_DIVU = 6'h1B;
    localparam logic [5:0] F_ADD  = 6'h20;
    localparam logic [5:0] F_ADDU = 6'h21;
    localparam logic [5:0] F_SUB  = 6'h22;
    localparam logic [5:0] F_SUBU = 6'h23;
    localparam logic [5:0] F_AND  = 6'h24;
    localparam logic [5:0] F_OR   = 6'h25;
    localparam logic [5:0] F_XOR  = 6'h26;
    localparam logic [5:0] F_NOR  = 6'h27;
    localparam logic [5:0] F_SLT  = 6'h2A;
    localparam logic [5:0] F_SLTU = 6'h2B;

    // Execute sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MULDIV,
        ST_COMMIT
    } t_state;

    // Multiply/divide unit states.
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX
    } t_md_state;

    // Request to the multiply/divide unit.
    typedef struct packed {
        logic start;
        logic div;
        logic sgn;
    } t_md_req;

endpackage

`default_nettype wire

[design/mre_muldiv.sv]
// ----------------------------------------------------------------------------
// mre_muldiv: iterative 32x32 multiply and 32/32 divide
// One shared 34-bit adder does a shift-add multiply or a restoring divide
// step per cycle on operand magnitudes; the final MD_FIX state applies the signs.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_muldiv
    import mre_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_md_req         i_req,
    input  wire logic [XLEN-1:0] i_a,
    input  wire logic [XLEN-1:0] i_b,
    output logic                 o_done,
    output logic [XLEN-1:0]      o_hi,
    output logic [XLEN-1:0]      o_lo
);

    t_md_state r_state;
    t_md_state n_state;

    logic [4:0]      r_cnt;
    logic            r_div;
    logic            r_neg_q;
    logic            r_neg_r;
    logic [XLEN-1:0] r_hi;
    logic [XLEN-1:0] r_lo;
    logic [XLEN-1:0] r_b;
    logic            r_done;
    logic [XLEN-1:0] r_res_hi;
    logic [XLEN-1:0] r_res_lo;

    logic            w_load;
    logic            w_step;
    logic            w_fix;
    logic [XLEN+1:0] w_opa;
    logic [XLEN+1:0] w_opb;
    logic            w_cin;
    logic [XLEN+1:0] w_sum;
    logic [XLEN-1:0] w_mag_a;
    logic [XLEN-1:0] w_mag_b;
    logic [2*XLEN-1:0] w_prod;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MD_IDLE: if (i_req.start) n_state = MD_RUN;
            MD_RUN:  if (r_cnt == MD_LAST) n_state = MD_FIX;
            MD_FIX:  n_state = MD_IDLE;
            default: n_state = MD_IDLE;
        endcase
    end

    // Control decode per state.
    always_comb begin
        w_load = 1'b0;
        w_step = 1'b0;
        w_fix  = 1'b0;
        unique case (r_state)
            MD_IDLE: w_load = i_req.start;
            MD_RUN:  w_step = 1'b1;
            MD_FIX:  w_fix  = 1'b1;
            default: w_load = 1'b0;
        endcase
    end

    // Operand magnitudes for signed requests.
    assign w_mag_a = (i_req.sgn && i_a[XLEN-1]) ? (~i_a + {{(XLEN-1){1'b0}}, 1'b1}) : i_a;
    assign w_mag_b = (i_req.sgn && i_b[XLEN-1]) ? (~i_b + {{(XLEN-1){1'b0}}, 1'b1}) : i_b;

    // Shared adder: add the multiplicand, or subtract the divisor.
    always_comb begin
        if (r_div) begin
            w_opa = {1'b0, r_hi, r_lo[XLEN-1]};
            w_opb = ~{2'b00, r_b};
            w_cin = 1'b1;
        end else begin
            w_opa = {2'b00, r_hi};
            w_opb = {2'b00, (r_lo[0] ? r_b : {XLEN{1'b0}})};
            w_cin = 1'b0;
        end
        w_sum = w_opa + w_opb + {{(XLEN+1){1'b0}}, w_cin};
    end

    assign w_prod = {r_hi, r_lo};

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_fix;
            if (w_load) begin
                r_cnt <= '0;
            end else if (w_step) begin
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_div   <= i_req.div;
            r_neg_q <= i_req.sgn & (i_a[XLEN-1] ^ i_b[XLEN-1]);
            r_neg_r <= i_req.sgn & i_a[XLEN-1];
            r_hi    <= '0;
            r_lo    <= w_mag_a;
            r_b     <= w_mag_b;
        end else if (w_step) begin
            if (r_div) begin
                // Restoring step: keep the difference when it is not negative.
                r_hi <= w_sum[XLEN+1] ? {r_hi[XLEN-2:0], r_lo[XLEN-1]} : w_sum[XLEN-1:0];
                r_lo <= {r_lo[XLEN-2:0], ~w_sum[XLEN+1]};
            end else begin
                r_hi <= w_sum[XLEN:1];
                r_lo <= {w_sum[0], r_lo[XLEN-1:1]};
            end
        end
    end

    // Sign correction of the finished result.
    always_ff @(posedge i_clk) begin
        if (w_fix) begin
            if (r_div) begin
                r_res_lo <= r_neg_q ? (~r_lo + {{(XLEN-1){1'b0}}, 1'b1}) : r_lo;
                r_res_hi <= r_neg_r ? (~r_hi + {{(XLEN-1){1'b0}}, 1'b1}) : r_hi;
            end else if (r_neg_q) begin
                {r_res_hi, r_res_lo} <= ~w_prod + {{(2*XLEN-1){1'b0}}, 1'b1};
            end else begin
                {r_res_hi, r_res_lo} <= w_prod;
            end
        end
    end

    assign o_done = r_done;
    assign o_hi   = r_res_hi;
    assign o_lo   = r_res_lo;

endmodule

`default_nettype wire

[design/mips_rtype_execute.sv]
// Flow: an accepted beat is captured, executed in ST_EXEC, and committed to
//   the output register from ST_COMMIT; multiply and divide pass ST_MULDIV.
// Throughput: one item at a time, since o_stall holds off new beats until the
//   last one commits; multiply and divide run 32 single-bit steps of the unit.
// Reset: synchronous, active low; clears the register file valid bits (all
//   registers read as zero), HI and LO, and all handshake state.
// ----------------------------------------------------------------------------
// mips_rtype_execute: MIPS32 R-type execute stage
// Executes one R-type instruction word per beat against a 32-entry register
// file and HI/LO, or writes a register from outside.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_rtype_execute
    import mre_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input channel
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_mode,
    input  wire logic [XLEN-1:0]   i_instr_word,
    input  wire logic [XLEN-1:0]   i_fetch_address,
    input  wire logic [RIDX_W-1:0] i_load_index,
    input  wire logic [XLEN-1:0]   i_load_value,
    // Output channel
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_write_enable,
    output logic [RIDX_W-1:0]      o_dest_index,
    output logic [XLEN-1:0]        o_write_value,
    output logic [XLEN-1:0]        o_hi_value,
    output logic [XLEN-1:0]        o_lo_value,
    output logic                   o_jump_taken,
    output logic [XLEN-1:0]        o_jump_target,
    output logic                   o_illegal
);

    t_state r_state;
    t_state n_state;

    // Register file storage and valid bits.
    logic [XLEN-1:0]    r_rf [REG_CNT];
    logic [REG_CNT-1:0] r_rf_vld;
    logic [XLEN-1:0]    r_rd_a;
    logic [XLEN-1:0]    r_rd_b;
    logic               r_rd_a_vld;
    logic               r_rd_b_vld;

    // Captured input beat.
    logic              r_mode;
    logic [XLEN-1:0]   r_instr;
    logic [XLEN-1:0]   r_pc;
    logic [RIDX_W-1:0] r_load_index;
    logic [XLEN-1:0]   r_load_value;

    // Architectural HI and LO.
    logic [XLEN-1:0] r_hi;
    logic [XLEN-1:0] r_lo;

    // Staged result of the execute cycle.
    logic              r_st_we;
    logic [RIDX_W-1:0] r_st_dest;
    logic [XLEN-1:0]   r_st_val;
    logic              r_st_jump;
    logic [XLEN-1:0]   r_st_target;
    logic              r_st_bad;
    logic              r_st_hilo_we;

    // Output register.
    logic              r_out_valid;
    logic              r_out_we;
    logic [RIDX_W-1:0] r_out_dest;
    logic [XLEN-1:0]   r_out_val;
    logic [XLEN-1:0]   r_out_hi;
    logic [XLEN-1:0]   r_out_lo;
    logic              r_out_jump;
    logic [XLEN-1:0]   r_out_target;
    logic              r_out_bad;

    // Control.
    logic w_accept;
    logic w_exec;
    logic w_commit;
    logic w_busy;
    logic w_out_free;
    logic w_take;
    logic w_rf_we;

    // Execute decode results.
    logic [XLEN-1:0]   w_a;
    logic [XLEN-1:0]   w_b;
    logic              x_we;
    logic [RIDX_W-1:0] x_dest;
    logic [XLEN-1:0]   x_val;
    logic              x_jump;
    logic [XLEN-1:0]   x_target;
    logic              x_bad;
    logic              x_is_md;
    logic              x_hilo_we;
    t_md_req           x_md_req;

    logic            w_md_done;
    logic [XLEN-1:0] w_md_hi;
    logic [XLEN-1:0] w_md_lo;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_take     = r_out_valid && !i_stall;

    // Next-state logic of the execute sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_EXEC;
            ST_EXEC:   n_state = x_is_md ? ST_MULDIV : ST_COMMIT;
            ST_MULDIV: if (w_md_done) n_state = ST_COMMIT;
            ST_COMMIT: if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_accept = 1'b0;
        w_exec   = 1'b0;
        w_commit = 1'b0;
        w_busy   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                w_busy   = 1'b0;
                w_accept = i_valid;
            end
            ST_EXEC:   w_exec   = 1'b1;
            ST_MULDIV: w_busy   = 1'b1;
            ST_COMMIT: w_commit = w_out_free;
            default:   w_busy   = 1'b1;
        endcase
    end

    assign o_stall = w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the input beat.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode       <= i_mode;
            r_instr      <= i_instr_word;
            r_pc         <= i_fetch_address;
            r_load_index <= i_load_index;
            r_load_value <= i_load_value;
        end
    end

    // Register file: two registered read ports, one write port.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_a <= r_rf[i_instr_word[25:21]];
            r_rd_b <= r_rf[i_instr_word[20:16]];
        end
        if (w_rf_we) begin
            r_rf[r_st_dest] <= r_st_val;
        end
    end

    // Valid bits: an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld   <= '0;
            r_rd_a_vld <= 1'b0;
            r_rd_b_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_rd_a_vld <= r_rf_vld[i_instr_word[25:21]];
                r_rd_b_vld <= r_rf_vld[i_instr_word[20:16]];
            end
            if (w_rf_we) begin
                r_rf_vld[r_st_dest] <= 1'b1;
            end
        end
    end

    assign w_a = r_rd_a_vld ? r_rd_a : '0;
    assign w_b = r_rd_b_vld ? r_rd_b : '0;

    // Instruction decode and combinational ALU.
    always_comb begin
        logic [5:0]      opc;
        logic [5:0]      fn;
        logic [4:0]      amt;
        logic [XLEN-1:0] sll_v;
        logic [XLEN-1:0] srl_v;
        logic [XLEN-1:0] sra_v;

        opc   = r_instr[31:26];
        fn    = r_instr[5:0];
        amt   = (fn == F_SLLV || fn == F_SRLV || fn == F_SRAV) ? w_a[4:0] : r_instr[10:6];
        sll_v = w_b << amt;
        srl_v = w_b >> amt;
        sra_v = $signed(w_b) >>> amt;

        x_we      = 1'b0;
        x_dest    = '0;
        x_val     = '0;
        x_jump    = 1'b0;
        x_target  = '0;
        x_bad     = 1'b0;
        x_is_md   = 1'b0;
        x_hilo_we = 1'b0;
        x_md_req  = '0;

        if (r_mode) begin
            x_we   = 1'b1;
            x_dest = r_load_index;
            x_val  = r_load_value;
        end else if (opc != OPC_SPECIAL) begin
            x_bad = 1'b1;
        end else begin
            x_we   = 1'b1;
            x_dest = r_instr[15:11];
            unique case (fn) inside
                F_SLL, F_SLLV: x_val = sll_v;
                F_SRL, F_SRLV: x_val = srl_v;
                F_SRA, F_SRAV: x_val = sra_v;
                F_JR: begin
                    x_we     = 1'b0;
                    x_jump   = 1'b1;
                    x_target = w_a;
                end
                F_JALR: begin
                    x_dest   = LINK_REG;
                    x_val    = r_pc + PC_STEP;
                    x_jump   = 1'b1;
                    x_target = w_a;
                end
                F_MFHI: x_val = r_hi;
                F_MFLO: x_val = r_lo;
                F_MULT, F_MULTU: begin
                    x_we         = 1'b0;
                    x_is_md      = 1'b1;
                    x_hilo_we    = 1'b1;
                    x_md_req.sgn = (fn == F_MULT);
                end
                F_DIV, F_DIVU: begin
                    // Division by zero leaves HI and LO untouched.
                    x_we         = 1'b0;
                    x_is_md      = 1'b1;
                    x_hilo_we    = (w_b != '0);
                    x_md_req.div = 1'b1;
                    x_md_req.sgn = (fn == F_DIV);
                end
                F_ADD, F_ADDU: x_val = w_a + w_b;
                F_SUB, F_SUBU: x_val = w_a - w_b;
                F_AND:  x_val = w_a & w_b;
                F_OR:   x_val = w_a | w_b;
                F_XOR:  x_val = w_a ^ w_b;
                F_NOR:  x_val = ~(w_a | w_b);
                F_SLT:  x_val = {{(XLEN-1){1'b0}}, ($signed(w_a) < $signed(w_b))};
                F_SLTU: x_val = {{(XLEN-1){1'b0}}, (w_a < w_b)};
                default: begin
                    x_we  = 1'b0;
                    x_bad = 1'b1;
                end
            endcase
        end
        x_md_req.start = w_exec && x_is_md;
    end

    // Iterative multiply/divide unit.
    mre_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (x_md_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_md_done),
        .o_hi    (w_md_hi),
        .o_lo    (w_md_lo)
    );

    // Stage the execute result; writes to r0 are dropped here.
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_st_we      <= x_we && (x_dest != '0);
            r_st_dest    <= (x_we && (x_dest != '0)) ? x_dest : '0;
            r_st_val     <= (x_we && (x_dest != '0)) ? x_val : '0;
            r_st_jump    <= x_jump;
            r_st_target  <= x_target;
            r_st_bad     <= x_bad;
            r_st_hilo_we <= x_hilo_we;
        end
    end

    assign w_rf_we = w_commit && r_st_we;

    // HI and LO update at commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end else if (w_commit && r_st_hilo_we) begin
            r_hi <= w_md_hi;
            r_lo <= w_md_lo;
        end
    end

    // Output register: holds the result beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_we     <= r_st_we;
            r_out_dest   <= r_st_dest;
            r_out_val    <= r_st_val;
            r_out_hi     <= r_st_hilo_we ? w_md_hi : r_hi;
            r_out_lo     <= r_st_hilo_we ? w_md_lo : r_lo;
            r_out_jump   <= r_st_jump;
            r_out_target <= r_st_target;
            r_out_bad    <= r_st_bad;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_write_enable = r_out_we;
    assign o_dest_index   = r_out_dest;
    assign o_write_value  = r_out_val;
    assign o_hi_value     = r_out_hi;
    assign o_lo_value     = r_out_lo;
    assign o_jump_taken   = r_out_jump;
    assign o_jump_target  = r_out_target;
    assign o_illegal      = r_out_bad;

    // The multiply/divide unit only finishes while the sequencer waits for it.
    a_md_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_done |-> r_state == ST_MULDIV)
        else $error("multiply/divide finished outside of its wait state");

    // A committed result is presented on the next cycle.
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid)
        else $error("committed result not presented");

    // An illegal item neither writes a register nor jumps.
    a_illegal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (!r_out_we && !r_out_jump))
        else $error("illegal item produced a write or a jump");

    // Register r0 is never written.
    a_no_r0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rf_we |-> r_st_dest != '0)
        else $error("write to register zero");

endmodule

`default_nettype wire

[tb/sv/mips_rtype_execute_tb.sv]
// ----------------------------------------------------------------------------
// mips_rtype_execute_tb: self-checking testbench for the R-type execute stage
// Drives instruction and register-write beats through the valid/stall input
// channel, predicts every result beat with an independent model of the
// register file and HI/LO, and compares each result beat field by field.
// Directed edge cases come first, then a backpressure phase and a long random
// phase with bursty input and a receiver that stalls on its own pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_rtype_execute_tb;
    import mre_pkg::*;

    // Item modes and instruction codes that the package does not name.
    localparam logic       MODE_EXEC = 1'b0;
    localparam logic       MODE_LOAD = 1'b1;
    localparam logic [5:0] OPC_LW    = 6'h23;
    localparam logic [5:0] F_UNUSED  = 6'h01;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES    = 60;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned RANDOM_ITEMS   = 460;

    // One predicted result beat.
    typedef struct packed {
        logic                we;
        logic [RIDX_W-1:0]   dest;
        logic [XLEN-1:0]     wval;
        logic [XLEN-1:0]     hi;
        logic [XLEN-1:0]     lo;
        logic                jmp;
        logic [XLEN-1:0]     target;
        logic                ill;
    } t_retire;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_mode;
    logic [XLEN-1:0]   i_instr_word;
    logic [XLEN-1:0]   i_fetch_address;
    logic [RIDX_W-1:0] i_load_index;
    logic [XLEN-1:0]   i_load_value;
    logic              o_valid;
    logic              i_stall;
    logic              o_write_enable;
    logic [RIDX_W-1:0] o_dest_index;
    logic [XLEN-1:0]   o_write_value;
    logic [XLEN-1:0]   o_hi_value;
    logic [XLEN-1:0]   o_lo_value;
    logic              o_jump_taken;
    logic [XLEN-1:0]   o_jump_target;
    logic              o_illegal;

    // Architectural state of the model and the retirements still owed.
    logic [XLEN-1:0] gpr [REG_CNT];
    logic [XLEN-1:0] hi_q;
    logic [XLEN-1:0] lo_q;
    t_retire         pending_retires [$];
    int unsigned     failures;

    // Long receiver hold-off, requested by the test and timed by the receiver.
    int unsigned hold_req;
    int unsigned hold_len;

    mips_rtype_execute dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_instr_word    (i_instr_word),
        .i_fetch_address (i_fetch_address),
        .i_load_index    (i_load_index),
        .i_load_value    (i_load_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_write_enable  (o_write_enable),
        .o_dest_index    (o_dest_index),
        .o_write_value   (o_write_value),
        .o_hi_value      (o_hi_value),
        .o_lo_value      (o_lo_value),
        .o_jump_taken    (o_jump_taken),
        .o_jump_target   (o_jump_target),
        .o_illegal       (o_illegal)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Executes one item against the model state and returns its result beat.
    function automatic t_retire predict_execute(input logic mode,
                                                input logic [XLEN-1:0] word,
                                                input logic [XLEN-1:0] pc,
                                                input logic [RIDX_W-1:0] lidx,
                                                input logic [XLEN-1:0] lval);
        t_retire           r;
        logic [RIDX_W-1:0] rs;
        logic [RIDX_W-1:0] rt;
        logic [RIDX_W-1:0] rd;
        logic [4:0]        sh;
        logic [5:0]        fn;
        logic [XLEN-1:0]   a;
        logic [XLEN-1:0]   b;
        logic [XLEN-1:0]   ma;
        logic [XLEN-1:0]   mb;
        logic [XLEN-1:0]   q;
        logic [XLEN-1:0]   rem;
        logic [63:0]       prod;
        r  = '0;
        rs = word[25:21];
        rt = word[20:16];
        rd = word[15:11];
        sh = word[10:6];
        fn = word[5:0];
        a  = gpr[rs];
        b  = gpr[rt];
        if (mode == MODE_LOAD) begin
            r.we   = 1'b1;
            r.dest = lidx;
            r.wval = lval;
        end else if (word[31:26] != OPC_SPECIAL) begin
            r.ill = 1'b1;
        end else begin
            r.we   = 1'b1;
            r.dest = rd;
            case (fn)
                F_SLL:  r.wval = b << sh;
                F_SRL:  r.wval = b >> sh;
                F_SRA:  r.wval = $signed(b) >>> sh;
                F_SLLV: r.wval = b << a[4:0];
                F_SRLV: r.wval = b >> a[4:0];
                F_SRAV: r.wval = $signed(b) >>> a[4:0];
                F_JR: begin
                    r.we     = 1'b0;
                    r.jmp    = 1'b1;
                    r.target = a;
                end
                F_JALR: begin
                    // Target is rs as read before the link lands in r31.
                    r.dest   = LINK_REG;
                    r.wval   = pc + PC_STEP;
                    r.jmp    = 1'b1;
                    r.target = a;
                end
                F_MFHI: r.wval = hi_q;
                F_MFLO: r.wval = lo_q;
                F_MULT: begin
                    r.we = 1'b0;
                    prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                    hi_q = prod[63:32];
                    lo_q = prod[31:0];
                end
                F_MULTU: begin
                    r.we = 1'b0;
                    prod = {32'd0, a} * {32'd0, b};
                    hi_q = prod[63:32];
                    lo_q = prod[31:0];
                end
                F_DIV: begin
                    // Divide by zero leaves HI and LO alone.
                    r.we = 1'b0;
                    if (b != '0) begin
                        ma  = a[31] ? -a : a;
                        mb  = b[31] ? -b : b;
                        q   = ma / mb;
                        rem = ma % mb;
                        if (a[31] ^ b[31]) q = -q;
                        if (a[31]) rem = -rem;
                        lo_q = q;
                        hi_q = rem;
                    end
                end
                F_DIVU: begin
                    r.we = 1'b0;
                    if (b != '0) begin
                        lo_q = a / b;
                        hi_q = a % b;
                    end
                end
                F_ADD, F_ADDU: r.wval = a + b;
                F_SUB, F_SUBU: r.wval = a - b;
                F_AND:  r.wval = a & b;
                F_OR:   r.wval = a | b;
                F_XOR:  r.wval = a ^ b;
                F_NOR:  r.wval = ~(a | b);
                F_SLT:  r.wval = {31'd0, $signed(a) < $signed(b)};
                F_SLTU: r.wval = {31'd0, a < b};
                default: begin
                    r.we  = 1'b0;
                    r.ill = 1'b1;
                end
            endcase
        end
        // Writes to r0 are dropped in both modes.
        if (!r.we || r.dest == '0) begin
            r.we   = 1'b0;
            r.dest = '0;
            r.wval = '0;
        end else begin
            gpr[r.dest] = r.wval;
        end
        r.hi = hi_q;
        r.lo = lo_q;
        return r;
    endfunction

    function automatic logic [XLEN-1:0] rtype(input logic [4:0] rs, input logic [4:0] rt,
                                              input logic [4:0] rd, input logic [4:0] sh,
                                              input logic [5:0] fn);
        return {OPC_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic funct_is_legal(input logic [5:0] fn);
        case (fn)
            F_SLL, F_SRL, F_SRA, F_SLLV, F_SRLV, F_SRAV, F_JR, F_JALR,
            F_MFHI, F_MFLO, F_MULT, F_MULTU, F_DIV, F_DIVU,
            F_ADD, F_ADDU, F_SUB, F_SUBU, F_AND, F_OR, F_XOR, F_NOR,
            F_SLT, F_SLTU: return 1'b1;
            default:       return 1'b0;
        endcase
    endfunction

    // Operand values weighted toward the arithmetic corners.
    function automatic logic [XLEN-1:0] operand_value();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'hFFFF_FFFF;
            5:       return XLEN'($urandom_range(63));
            default: return $urandom();
        endcase
    endfunction

    // Offers one beat from the falling edge and holds it until accepted.
    task automatic send_item(input logic mode, input logic [XLEN-1:0] word,
                             input logic [XLEN-1:0] pc, input logic [RIDX_W-1:0] lidx,
                             input logic [XLEN-1:0] lval);
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_instr_word    <= word;
        i_fetch_address <= pc;
        i_load_index    <= lidx;
        i_load_value    <= lval;
        do @(posedge i_clk); while (o_stall);
        pending_retires.push_back(predict_execute(mode, word, pc, lidx, lval));
    endtask

    task automatic load_reg(input logic [RIDX_W-1:0] idx, input logic [XLEN-1:0] val);
        send_item(MODE_LOAD, $urandom(), $urandom(), idx, val);
    endtask

    task automatic exec_word(input logic [XLEN-1:0] word);
        send_item(MODE_EXEC, word, $urandom(), RIDX_W'($urandom()), $urandom());
    endtask

    // Drops valid for a number of cycles.
    task automatic pause(input int unsigned cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Stops offering beats until every owed result has come back.
    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_retires.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        int unsigned     pick;
        logic [5:0]      fn;
        logic [XLEN-1:0] word;
        logic [XLEN-1:0] pc;
        pick = $urandom_range(99);
        pc   = ($urandom_range(7) == 0) ? 32'hFFFF_FFFC : $urandom();
        if (pick < 20) begin
            send_item(MODE_LOAD, $urandom(), pc, RIDX_W'($urandom()), operand_value());
        end else begin
            if (pick < 90) begin
                do fn = 6'($urandom()); while (!funct_is_legal(fn));
                word = rtype(5'($urandom()), 5'($urandom()), 5'($urandom()),
                             5'($urandom()), fn);
            end else if (pick < 95) begin
                word = $urandom();
            end else begin
                do fn = 6'($urandom()); while (funct_is_legal(fn));
                word = rtype(5'($urandom()), 5'($urandom()), 5'($urandom()),
                             5'($urandom()), fn);
            end
            send_item(MODE_EXEC, word, pc, RIDX_W'($urandom()), $urandom());
        end
    endtask

    // Register writes from outside, wrapping add/sub, logic ops and compares.
    task automatic test_alu_edges();
        load_reg(5'd0, $urandom() | 32'd1);
        load_reg(5'd1, 32'h7FFF_FFFF);
        load_reg(5'd2, 32'h8000_0000);
        load_reg(5'd3, 32'hFFFF_FFFF);
        exec_word(rtype(5'd2, 5'd2, 5'd6, 5'd0, F_ADD));
        exec_word(rtype(5'd3, 5'd3, 5'd7, 5'd3, F_ADDU));
        exec_word(rtype(5'd2, 5'd1, 5'd8, 5'd0, F_SUB));
        exec_word(rtype(5'd0, 5'd3, 5'd9, 5'd0, F_SUBU));
        // The AND targets r0, so its write must be dropped.
        exec_word(rtype(5'd2, 5'd3, 5'd0, 5'd0, F_AND));
        exec_word(rtype(5'd1, 5'd2, 5'd11, 5'd0, F_OR));
        exec_word(rtype(5'd1, 5'd3, 5'd12, 5'd0, F_XOR));
        exec_word(rtype(5'd0, 5'd0, 5'd13, 5'd0, F_NOR));
        exec_word(rtype(5'd2, 5'd1, 5'd14, 5'd0, F_SLT));
        exec_word(rtype(5'd2, 5'd1, 5'd15, 5'd0, F_SLTU));
    endtask

    // Fixed shifts by 31 and variable shifts that use only the low bits of rs.
    task automatic test_shift_edges();
        exec_word(rtype(5'd0, 5'd1, 5'd16, 5'd31, F_SLL));
        exec_word(rtype(5'd0, 5'd2, 5'd17, 5'd31, F_SRL));
        exec_word(rtype(5'd0, 5'd2, 5'd18, 5'd31, F_SRA));
        exec_word(rtype(5'd3, 5'd1, 5'd19, 5'd0, F_SLLV));
        exec_word(rtype(5'd3, 5'd3, 5'd20, 5'd0, F_SRLV));
        exec_word(rtype(5'd1, 5'd2, 5'd21, 5'd0, F_SRAV));
    endtask

    // 64-bit products, the most negative over minus one, and divide by zero.
    task automatic test_muldiv_edges();
        exec_word(rtype(5'd2, 5'd3, 5'd0, 5'd0, F_MULT));
        exec_word(rtype(5'd0, 5'd0, 5'd22, 5'd0, F_MFLO));
        exec_word(rtype(5'd3, 5'd3, 5'd0, 5'd0, F_MULTU));
        exec_word(rtype(5'd0, 5'd0, 5'd23, 5'd0, F_MFHI));
        exec_word(rtype(5'd2, 5'd3, 5'd0, 5'd0, F_DIV));
        exec_word(rtype(5'd1, 5'd0, 5'd0, 5'd0, F_DIVU));
    endtask

    // Links, a link that wraps, jalr through r31 itself, and illegal words.
    task automatic test_jumps_and_illegal();
        send_item(MODE_EXEC, rtype(5'd31, 5'd0, 5'd5, 5'd0, F_JALR), 32'h0040_0000, '0, '0);
        send_item(MODE_EXEC, rtype(5'd31, 5'd0, 5'd5, 5'd0, F_JALR), 32'hFFFF_FFFC, '0, '0);
        exec_word(rtype(5'd3, 5'd0, 5'd0, 5'd0, F_JR));
        exec_word({OPC_LW, 26'($urandom())});
        exec_word(rtype(5'd1, 5'd2, 5'd24, 5'd0, F_UNUSED));
    endtask

    // Receiver holds off while the sender keeps offering, then a full drain.
    task automatic test_input_backpressure();
        hold_len = HOLD_CYCLES;
        hold_req++;
        repeat (10) send_random_item();
        wait_drain();
    endtask

    // Bursts of random items with random gaps and an occasional full drain.
    task automatic test_random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                if (sent < count) begin
                    send_random_item();
                    sent++;
                end
            end
            if ($urandom_range(11) == 0) wait_drain();
            else if ($urandom_range(2) != 0) pause($urandom_range(1, 10));
        end
    endtask

    // Receiver stall pattern: random density per stretch, plus long hold-offs.
    initial begin : receiver
        int unsigned density;
        int unsigned span;
        int unsigned hold_left;
        int unsigned hold_ack;
        i_stall   = 1'b0;
        density   = 0;
        span      = 0;
        hold_left = 0;
        hold_ack  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_ack != hold_req) begin
                hold_ack  = hold_req;
                hold_left = hold_len;
            end
            if (span == 0) begin
                case ($urandom_range(3))
                    0:       density = 0;
                    1:       density = 25;
                    2:       density = 50;
                    default: density = 85;
                endcase
                span = $urandom_range(40, 160);
            end
            span--;
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < density);
            end
        end
    end

    task automatic check_field(input string name, input logic [XLEN-1:0] want,
                               input logic [XLEN-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
            failures++;
        end
    endtask

    // Compare each accepted result beat with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_retire e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_retires.size() == 0) begin
                $error("result beat with no prediction waiting");
                failures++;
            end else begin
                e = pending_retires.pop_front();
                check_field("write_enable", XLEN'(e.we), XLEN'(o_write_enable));
                check_field("dest_index", XLEN'(e.dest), XLEN'(o_dest_index));
                check_field("write_value", e.wval, o_write_value);
                check_field("hi_value", e.hi, o_hi_value);
                check_field("lo_value", e.lo, o_lo_value);
                check_field("jump_taken", XLEN'(e.jmp), XLEN'(o_jump_taken));
                check_field("jump_target", e.target, o_jump_target);
                check_field("illegal", XLEN'(e.ill), XLEN'(o_illegal));
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Reset, then the tests in turn, then drain and report.
    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_mode          = MODE_EXEC;
        i_instr_word    = '0;
        i_fetch_address = '0;
        i_load_index    = '0;
        i_load_value    = '0;
        hold_req        = 0;
        hold_len        = 0;
        failures        = 0;
        foreach (gpr[k]) gpr[k] = '0;
        hi_q = '0;
        lo_q = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_alu_edges();
        test_shift_edges();
        test_muldiv_edges();
        test_jumps_and_illegal();
        test_input_backpressure();
        test_random_traffic(RANDOM_ITEMS);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[mips_rtype_execute.f]
design/mre_pkg.sv
design/mre_muldiv.sv
design/mips_rtype_execute.sv
tb/sv/mips_rtype_execute_tb.sv
